// File: hw/rtl/rcso_pkg.sv
// ---------------------------------------------------------------------------
// rcso_pkg: shared types, constants and functions of the SOC observer update
// Beat formats, internal word format helpers, ALU op codes and the
// micro-program that the back end steps through.
// ---------------------------------------------------------------------------
package rcso_pkg;

	// internal word: signed 64 bit with WORD_BITS fraction bits
	localparam int WORD_BITS = 32;
	localparam int XW        = 64;
	localparam int NUM_W     = XW + WORD_BITS;   // dividend width after scaling

	typedef struct packed {
		logic signed [31:0] soc_older;
		logic signed [31:0] soc_previous;
		logic signed [31:0] current_a;
		logic signed [31:0] current_b;
		logic signed [31:0] current_c;
		logic signed [31:0] voltage_a;
		logic signed [31:0] voltage_b;
		logic signed [31:0] voltage_c;
		logic        [30:0] polar_resistance;
		logic        [30:0] polar_capacitance;
		logic signed [31:0] ocv_slope;
	} in_t;

	typedef struct packed {
		logic signed [31:0] soc_next;
		logic               math_error;
	} out_t;

	typedef struct packed {
		logic signed [31:0] gain_one;
		logic signed [31:0] gain_two;
		logic        [23:0] capacity_amp_seconds;
		logic        [30:0] sample_period;
	} cfg_t;

	// configuration register indexes
	localparam logic [7:0] CFG_GAIN_ONE = 8'd0;
	localparam logic [7:0] CFG_GAIN_TWO = 8'd1;
	localparam logic [7:0] CFG_CAPACITY = 8'd2;
	localparam logic [7:0] CFG_PERIOD   = 8'd3;

	// queue status, front to top
	typedef struct packed {
		logic head_valid;
		logic full;
	} fe_stat_t;

	// ALU op codes
	localparam logic [1:0] OP_ADD = 2'd0;
	localparam logic [1:0] OP_SUB = 2'd1;
	localparam logic [1:0] OP_MUL = 2'd2;
	localparam logic [1:0] OP_DIV = 2'd3;

	typedef struct packed {
		logic [1:0]         op;
		logic signed [63:0] a;
		logic signed [63:0] b;
	} alu_req_t;

	typedef struct packed {
		logic               done;
		logic               dz;
		logic signed [63:0] res;
	} alu_rsp_t;

	// register file map: loaded operands first, then temporaries
	localparam logic [4:0] R_S2    = 5'd0;
	localparam logic [4:0] R_S1    = 5'd1;
	localparam logic [4:0] R_IA    = 5'd2;
	localparam logic [4:0] R_IB    = 5'd3;
	localparam logic [4:0] R_IC    = 5'd4;
	localparam logic [4:0] R_VA    = 5'd5;
	localparam logic [4:0] R_VB    = 5'd6;
	localparam logic [4:0] R_VC    = 5'd7;
	localparam logic [4:0] R_RP    = 5'd8;
	localparam logic [4:0] R_CP    = 5'd9;
	localparam logic [4:0] R_SL    = 5'd10;
	localparam logic [4:0] R_L1    = 5'd11;
	localparam logic [4:0] R_L2    = 5'd12;
	localparam logic [4:0] R_QR    = 5'd13;
	localparam logic [4:0] R_TS    = 5'd14;
	localparam logic [4:0] R_ONE   = 5'd15;
	localparam logic [4:0] R_FOUR  = 5'd16;
	localparam logic [4:0] R_EIGHT = 5'd17;
	localparam logic [4:0] T18 = 5'd18;
	localparam logic [4:0] T19 = 5'd19;
	localparam logic [4:0] T20 = 5'd20;
	localparam logic [4:0] T21 = 5'd21;
	localparam logic [4:0] T22 = 5'd22;
	localparam logic [4:0] T23 = 5'd23;
	localparam logic [4:0] T24 = 5'd24;
	localparam logic [4:0] T25 = 5'd25;
	localparam logic [4:0] T26 = 5'd26;
	localparam logic [4:0] T27 = 5'd27;
	localparam logic [4:0] T28 = 5'd28;
	localparam logic [4:0] T29 = 5'd29;
	localparam logic [4:0] T30 = 5'd30;
	localparam logic [4:0] R_ACC = 5'd31;

	localparam int N_LOAD = 18;
	localparam int N_PROG = 57;

	typedef struct packed {
		logic [1:0] op;
		logic [4:0] dst;
		logic [4:0] sa;
		logic [4:0] sb;
	} instr_t;

	function automatic logic [63:0] mag64(input logic signed [63:0] v);
		mag64 = v[63] ? 64'(-v) : 64'(v);
	endfunction

	// signed magnitude to saturated 64-bit word
	function automatic logic signed [63:0] pack(input logic neg, input logic [127:0] m);
		logic signed [63:0] r;
		if (neg) begin
			if (m > 128'h8000_0000_0000_0000) r = 64'sh8000_0000_0000_0000;
			else                              r = -$signed(m[63:0]);
		end else begin
			if (m > 128'h7FFF_FFFF_FFFF_FFFF) r = 64'sh7FFF_FFFF_FFFF_FFFF;
			else                              r = $signed(m[63:0]);
		end
		pack = r;
	endfunction

	function automatic logic signed [63:0] sat_addsub(input logic signed [63:0] a,
			input logic signed [63:0] b, input logic sub);
		logic [64:0] s;
		logic signed [63:0] r;
		s = sub ? ({a[63], a} - {b[63], b}) : ({a[63], a} + {b[63], b});
		if (s[64] != s[63]) r = s[64] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
		else                r = $signed(s[63:0]);
		sat_addsub = r;
	endfunction

	// operand loaded into the register file at a given slot
	function automatic logic signed [63:0] ld_value(input logic [4:0] idx, input in_t it,
			input cfg_t c);
		logic signed [63:0] v;
		unique case (idx)
			R_S2:    v = 64'(it.soc_older)    <<< (WORD_BITS - 30);
			R_S1:    v = 64'(it.soc_previous) <<< (WORD_BITS - 30);
			R_IA:    v = 64'(it.current_a)    <<< (WORD_BITS - 16);
			R_IB:    v = 64'(it.current_b)    <<< (WORD_BITS - 16);
			R_IC:    v = 64'(it.current_c)    <<< (WORD_BITS - 16);
			R_VA:    v = 64'(it.voltage_a)    <<< (WORD_BITS - 16);
			R_VB:    v = 64'(it.voltage_b)    <<< (WORD_BITS - 16);
			R_VC:    v = 64'(it.voltage_c)    <<< (WORD_BITS - 16);
			R_RP:    v = $signed(64'(it.polar_resistance))  <<< (WORD_BITS - 24);
			R_CP:    v = $signed(64'(it.polar_capacitance)) <<< (WORD_BITS - 8);
			R_SL:    v = 64'(it.ocv_slope)    <<< (WORD_BITS - 16);
			R_L1:    v = 64'(c.gain_one)      <<< (WORD_BITS - 16);
			R_L2:    v = 64'(c.gain_two)      <<< (WORD_BITS - 16);
			R_QR:    v = $signed(64'(c.capacity_amp_seconds)) <<< WORD_BITS;
			R_TS:    v = $signed(64'(c.sample_period)) <<< (WORD_BITS - 24);
			R_ONE:   v = 64'sd1 <<< WORD_BITS;
			R_FOUR:  v = 64'sd4 <<< WORD_BITS;
			R_EIGHT: v = 64'sd8 <<< WORD_BITS;
			default: v = '0;
		endcase
		ld_value = v;
	endfunction

	function automatic instr_t mk(input logic [1:0] op, input logic [4:0] d,
			input logic [4:0] a, input logic [4:0] b);
		mk = '{op: op, dst: d, sa: a, sb: b};
	endfunction

	// observer update micro-program
	function automatic instr_t prog(input logic [5:0] pc);
		instr_t i;
		unique case (pc)
			6'd0:  i = mk(OP_MUL, T18, R_RP, R_CP);     // rc
			6'd1:  i = mk(OP_DIV, T19, R_ONE, T18);     // inv
			6'd2:  i = mk(OP_MUL, T20, R_L2, R_SL);     // ls
			6'd3:  i = mk(OP_ADD, T21, T19, R_L1);      // inv + L1
			6'd4:  i = mk(OP_ADD, T22, T21, T20);       // k1
			6'd5:  i = mk(OP_DIV, T23, T20, T18);       // k2
			6'd6:  i = mk(OP_MUL, T24, R_L2, R_QR);
			6'd7:  i = mk(OP_DIV, T24, T24, R_CP);
			6'd8:  i = mk(OP_SUB, T21, T21, T24);       // k3
			6'd9:  i = mk(OP_MUL, T25, R_TS, R_TS);     // T2
			6'd10: i = mk(OP_MUL, T22, T22, R_TS);      // p
			6'd11: i = mk(OP_MUL, T23, T25, T23);       // q
			6'd12: i = mk(OP_MUL, T21, T21, T25);       // r
			6'd13: i = mk(OP_MUL, T24, R_L2, T19);
			6'd14: i = mk(OP_MUL, T24, T24, T25);       // m
			6'd15: i = mk(OP_MUL, T26, R_L2, R_TS);
			6'd16: i = mk(OP_ADD, T26, T26, T26);       // n
			6'd17: i = mk(OP_ADD, T27, R_TS, R_TS);     // 2T
			6'd18: i = mk(OP_ADD, T22, T22, T22);       // 2p
			6'd19: i = mk(OP_ADD, T28, R_FOUR, T22);
			6'd20: i = mk(OP_ADD, T28, T28, T23);       // b1
			6'd21: i = mk(OP_ADD, T19, T23, T23);
			6'd22: i = mk(OP_SUB, T19, R_EIGHT, T19);   // b2
			6'd23: i = mk(OP_SUB, T25, T22, T23);
			6'd24: i = mk(OP_SUB, T25, T25, R_FOUR);    // b3
			6'd25: i = mk(OP_ADD, T29, T27, T21);
			6'd26: i = mk(OP_DIV, T29, T29, R_QR);      // b4
			6'd27: i = mk(OP_ADD, T30, T21, T21);
			6'd28: i = mk(OP_DIV, T30, T30, R_QR);      // b5
			6'd29: i = mk(OP_SUB, T21, T21, T27);
			6'd30: i = mk(OP_DIV, T21, T21, R_QR);      // b6
			6'd31: i = mk(OP_ADD, T23, T24, T26);       // b7
			6'd32: i = mk(OP_ADD, T27, T24, T24);       // b8
			6'd33: i = mk(OP_SUB, T24, T24, T26);       // b9
			6'd34: i = mk(OP_DIV, T19, T19, T28);
			6'd35: i = mk(OP_MUL, R_ACC, R_S1, T19);
			6'd36: i = mk(OP_DIV, T25, T25, T28);
			6'd37: i = mk(OP_MUL, T25, R_S2, T25);
			6'd38: i = mk(OP_ADD, R_ACC, R_ACC, T25);
			6'd39: i = mk(OP_DIV, T29, T29, T28);
			6'd40: i = mk(OP_MUL, T29, R_IC, T29);
			6'd41: i = mk(OP_ADD, R_ACC, R_ACC, T29);
			6'd42: i = mk(OP_DIV, T30, T30, T28);
			6'd43: i = mk(OP_MUL, T30, R_IB, T30);
			6'd44: i = mk(OP_ADD, R_ACC, R_ACC, T30);
			6'd45: i = mk(OP_DIV, T21, T21, T28);
			6'd46: i = mk(OP_MUL, T21, R_IA, T21);
			6'd47: i = mk(OP_ADD, R_ACC, R_ACC, T21);
			6'd48: i = mk(OP_DIV, T23, T23, T28);
			6'd49: i = mk(OP_MUL, T23, R_VC, T23);
			6'd50: i = mk(OP_ADD, R_ACC, R_ACC, T23);
			6'd51: i = mk(OP_DIV, T27, T27, T28);
			6'd52: i = mk(OP_MUL, T27, R_VB, T27);
			6'd53: i = mk(OP_ADD, R_ACC, R_ACC, T27);
			6'd54: i = mk(OP_DIV, T24, T24, T28);
			6'd55: i = mk(OP_MUL, T24, R_VA, T24);
			6'd56: i = mk(OP_ADD, R_ACC, R_ACC, T24);
			default: i = mk(OP_ADD, R_ACC, R_ACC, T18);
		endcase
		prog = i;
	endfunction

endpackage

// File: hw/rtl/rc_model_soc_observer_update_core.sv
// ---------------------------------------------------------------------------
// rc_model_soc_observer_update_core: SOC observer update, first-order RC model
// Top level: configuration registers, intake queue and observer sequencer.
// ---------------------------------------------------------------------------
// Start a beat by raising start while busy is low; the sample set is taken
// at that edge. Each beat gives one result on result, marked by done for
// exactly one cycle, and the receiver cannot stall it, so capture it then.
// A two-entry queue sits ahead of the sequencer: two further beats can be
// issued while one is being worked on; busy rises when the queue is full.
// In the sequencer a beat passes through idle, a load of 18 operands, then 57
// program steps (25 add/sub, 18 multiplies and 14 divides), then a read-out
// of the sum. The bit-serial divider, one quotient bit a cycle over 96 bits,
// makes the divides the longest steps; a divide by zero skips the serial
// steps, so an error beat finishes earlier. math_error flags a zero divisor
// (Rp*Cp, Cp, capacity or b1); the SOC is then 0. Registers are written over
// the cfg channel (always ready) and are only to be changed while no beat is
// in flight.

module rc_model_soc_observer_update_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  rcso_pkg::in_t       item,
	output logic                done,
	output rcso_pkg::out_t      result,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [7:0]          cfg_index,
	input  logic [31:0]         cfg_data
);

	rcso_pkg::cfg_t     cfg_q;
	rcso_pkg::in_t      head;
	rcso_pkg::fe_stat_t fe_stat;
	logic               pop;

	// register port never stalls
	assign cfg_ready = 1'b1;

	// unknown indexes fall through and leave every register as it was
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_one             <= '0;
			cfg_q.gain_two             <= '0;
			cfg_q.capacity_amp_seconds <= 24'd9000;
			cfg_q.sample_period        <= 31'd16777216;   // 1.0 s
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				rcso_pkg::CFG_GAIN_ONE: cfg_q.gain_one <= $signed(cfg_data);
				rcso_pkg::CFG_GAIN_TWO: cfg_q.gain_two <= $signed(cfg_data);
				rcso_pkg::CFG_CAPACITY: cfg_q.capacity_amp_seconds <= cfg_data[23:0];
				rcso_pkg::CFG_PERIOD:   cfg_q.sample_period <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	// intake: accepts beats, queues them
	rcso_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.item   (item),
		.pop    (pop),
		.busy   (busy),
		.head   (head),
		.stat   (fe_stat)
	);

	// execution: register file, micro-program, shared ALU
	rcso_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (fe_stat.head_valid),
		.head       (head),
		.cfg        (cfg_q),
		.pop        (pop),
		.done       (done),
		.result     (result)
	);

	// a full queue always has a head to offer
	a_full_has_head: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> fe_stat.head_valid)
		else $error("queue full without head");

	// done is never raised for two results back to back
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("back-to-back results");

	// an error result carries a zero SOC
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.math_error |-> result.soc_next == 32'sd0)
		else $error("error result with non-zero SOC");

	// the sequencer never pops an empty queue
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> fe_stat.head_valid)
		else $error("pop from empty queue");

endmodule

// File: hw/rtl/rcso_alu.sv
// ---------------------------------------------------------------------------
// rcso_alu: shared arithmetic unit
// Saturating add/subtract, rounded multiply from four 32x32 partial
// products, truncating restoring divide at one quotient bit a cycle.
// ---------------------------------------------------------------------------
module rcso_alu (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               go,
	input  rcso_pkg::alu_req_t req,
	output rcso_pkg::alu_rsp_t rsp
);

	logic [1:0]         op_q;
	logic               neg_q;
	logic [63:0]        xm_q, ym_q;
	logic [127:0]       acc_q;
	logic [63:0]        pp_q;
	logic [1:0]         sh_q;
	logic [6:0]         cnt_q;
	logic [rcso_pkg::NUM_W-1:0] num_q, quo_q;
	logic [63:0]        rem_q;
	logic               run_q, done_q, dz_q;
	logic signed [63:0] res_q;

	logic [31:0]  xpart, ypart;
	logic [64:0]  rs;
	logic         ge;
	logic [127:0] rnd;

	assign xpart = cnt_q[1] ? xm_q[63:32] : xm_q[31:0];
	assign ypart = cnt_q[0] ? ym_q[63:32] : ym_q[31:0];
	assign rs    = {rem_q, num_q[rcso_pkg::NUM_W-1]};
	assign ge    = rs >= {1'b0, ym_q};
	assign rnd   = acc_q + (128'd1 << (rcso_pkg::WORD_BITS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				op_q <= req.op;
				neg_q <= req.a[63] != req.b[63];
				xm_q <= rcso_pkg::mag64(req.a);
				ym_q <= rcso_pkg::mag64(req.b);
				acc_q <= '0;
				cnt_q <= '0;
				rem_q <= '0;
				quo_q <= '0;
				num_q <= {rcso_pkg::mag64(req.a), rcso_pkg::WORD_BITS'(0)};
				dz_q <= 1'b0;
				unique case (req.op)
					rcso_pkg::OP_ADD, rcso_pkg::OP_SUB: begin
						res_q  <= rcso_pkg::sat_addsub(req.a, req.b,
							req.op == rcso_pkg::OP_SUB);
						done_q <= 1'b1;
					end
					rcso_pkg::OP_MUL: begin
						run_q <= 1'b1;
					end
					rcso_pkg::OP_DIV: begin
						if (req.b == '0) begin
							res_q  <= '0;
							dz_q   <= 1'b1;
							done_q <= 1'b1;
						end else begin
							run_q <= 1'b1;
						end
					end
				endcase
			end else if (run_q) begin
				cnt_q <= cnt_q + 7'd1;
				if (op_q == rcso_pkg::OP_MUL) begin
					if (cnt_q < 7'd4) begin
						pp_q <= xpart * ypart;
						sh_q <= 2'(cnt_q[1]) + 2'(cnt_q[0]);
					end
					if (cnt_q != 7'd0 && cnt_q < 7'd5)
						acc_q <= acc_q + ({64'd0, pp_q} << {sh_q, 5'd0});
					if (cnt_q == 7'd5) begin
						res_q  <= rcso_pkg::pack(neg_q, rnd >> rcso_pkg::WORD_BITS);
						done_q <= 1'b1;
						run_q  <= 1'b0;
					end
				end else begin
					if (cnt_q < 7'(rcso_pkg::NUM_W)) begin
						rem_q <= ge ? 64'(rs - {1'b0, ym_q}) : rs[63:0];
						num_q <= num_q << 1;
						quo_q <= {quo_q[rcso_pkg::NUM_W-2:0], ge};
					end else begin
						res_q  <= rcso_pkg::pack(neg_q, 128'(quo_q));
						done_q <= 1'b1;
						run_q  <= 1'b0;
					end
				end
			end
		end
	end

	assign rsp = '{done: done_q, dz: dz_q, res: res_q};

endmodule

// File: hw/rtl/rcso_front.sv
// ---------------------------------------------------------------------------
// rcso_front: command intake
// Takes sample-set beats and holds them in a two-entry queue for the back end.
// ---------------------------------------------------------------------------
module rcso_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  rcso_pkg::in_t      item,
	input  logic               pop,
	output logic               busy,
	output rcso_pkg::in_t      head,
	output rcso_pkg::fe_stat_t stat
);

	rcso_pkg::in_t q_q [2];
	logic          wp_q, rp_q;
	logic [1:0]    cnt_q;
	logic          push;

	assign busy = cnt_q == 2'd2;
	assign push = start && !busy;
	assign head = q_q[rp_q];
	assign stat = '{head_valid: cnt_q != 2'd0, full: busy};

	always_ff @(posedge clk) begin
		if (push) q_q[wp_q] <= item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (pop)  rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule

// File: hw/rtl/rcso_back.sv
// ---------------------------------------------------------------------------
// rcso_back: observer sequencer
// Loads one sample set into a register file, runs the update program on the
// shared ALU, and rescales the accumulated sum to the Q2.30 result.
// ---------------------------------------------------------------------------
module rcso_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               head_valid,
	input  rcso_pkg::in_t      head,
	input  rcso_pkg::cfg_t     cfg,
	output logic               pop,
	output logic               done,
	output rcso_pkg::out_t     result
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_LOAD = 3'd1;
	localparam logic [2:0] ST_READ = 3'd2;
	localparam logic [2:0] ST_EXEC = 3'd3;
	localparam logic [2:0] ST_WAIT = 3'd4;
	localparam logic [2:0] ST_FRD  = 3'd5;
	localparam logic [2:0] ST_FOUT = 3'd6;

	localparam int SH = rcso_pkg::WORD_BITS - 30;

	logic [2:0] state_q;
	logic [5:0] pc_q;
	logic [4:0] ld_q;
	logic       err_q;
	logic       done_q;
	rcso_pkg::out_t res_q;

	logic signed [63:0] rf [32];
	logic signed [63:0] rda_q, rdb_q;

	rcso_pkg::instr_t   ins;
	rcso_pkg::alu_req_t alu_req;
	rcso_pkg::alu_rsp_t rsp;
	logic               alu_go;
	logic [4:0]         ra;
	logic               we;
	logic [4:0]         wa;
	logic signed [63:0] wd;
	logic [63:0]        fmag, frnd;
	logic signed [31:0] fsat;

	assign ins    = rcso_pkg::prog(pc_q);
	assign ra     = (state_q == ST_FRD) ? rcso_pkg::R_ACC : ins.sa;
	assign alu_go = state_q == ST_EXEC;
	assign pop    = state_q == ST_LOAD && ld_q == 5'(rcso_pkg::N_LOAD - 1);

	always_comb begin
		we = 1'b0;
		wa = ld_q;
		wd = rcso_pkg::ld_value(ld_q, head, cfg);
		if (state_q == ST_LOAD) begin
			we = 1'b1;
		end else if (state_q == ST_WAIT && rsp.done) begin
			we = 1'b1;
			wa = ins.dst;
			wd = rsp.res;
		end
	end

	always_ff @(posedge clk) begin
		if (we) rf[wa] <= wd;
		rda_q <= rf[ra];
		rdb_q <= rf[ins.sb];
	end

	assign alu_req = '{op: ins.op, a: rda_q, b: rdb_q};

	rcso_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (alu_go),
		.req    (alu_req),
		.rsp    (rsp)
	);

	// final rescale to Q2.30, half away from zero, then clamp to 32 bits
	always_comb begin
		fmag = rcso_pkg::mag64(rda_q);
		frnd = (fmag + (64'd1 << (SH - 1))) >> SH;
		if (rda_q[63]) fsat = (frnd > 64'h8000_0000) ? 32'sh8000_0000 : -$signed(frnd[31:0]);
		else           fsat = (frnd > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(frnd[31:0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pc_q    <= '0;
			ld_q    <= '0;
			err_q   <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					ld_q <= '0;
					if (head_valid) state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					ld_q <= ld_q + 5'd1;
					if (pop) begin
						pc_q    <= '0;
						err_q   <= 1'b0;
						state_q <= ST_READ;
					end
				end
				ST_READ: state_q <= ST_EXEC;
				ST_EXEC: state_q <= ST_WAIT;
				ST_WAIT: begin
					if (rsp.done) begin
						err_q <= err_q | rsp.dz;
						pc_q  <= pc_q + 6'd1;
						state_q <= (pc_q == 6'(rcso_pkg::N_PROG - 1)) ? ST_FRD : ST_READ;
					end
				end
				ST_FRD: state_q <= ST_FOUT;
				ST_FOUT: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FOUT)
			res_q <= '{soc_next: err_q ? 32'sd0 : fsat, math_error: err_q};
	end

	assign done   = done_q;
	assign result = res_q;

endmodule
